[sv/sine_nco_oscillator_core_assert.svh]
// Assertion macros shared by the sine NCO RTL files.
`ifndef SINE_NCO_OSCILLATOR_CORE_ASSERT_SVH
`define SINE_NCO_OSCILLATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted
`define SNO_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sine nco assertion failed");
// Clocked check that also holds through reset
`define SNO_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("sine nco assertion failed");
`else
`define SNO_ASSERT(label, clk, rst_n, prop)
`define SNO_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[sv/sno_pkg.sv]
// Shared types, constants and sine table math for the sine NCO.
`default_nettype none

package sno_pkg;

    // Register index and reset value of the step-per-hertz register
    localparam int unsigned REG_STEP_PER_HZ = 0;
    localparam logic [39:0] STEP_RESET      = 40'd6382652533;

    // Peak amplitude of the output sine
    localparam logic [15:0] AMPLITUDE       = 16'd32767;

    // pi/2 in unsigned Q2.62
    localparam logic [63:0] HALFPI_Q62      = 64'h6487ED5110B4611A;

    // Per-sample lookup flags handed from the phase stage to the table stage
    typedef struct packed {
        logic zero;   // oscillator idle, sample is zero
        logic neg;    // second half of the cycle, negate the magnitude
        logic peak;   // quarter point, magnitude is the full amplitude
    } sno_lut_flags_t;

    // (a * b) >> 62 for Q2.62 operands, truncated
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        return p[125:62];
    endfunction

    // Quarter-wave magnitude for index j of a table with 2^table_bits entries.
    // Taylor series of sine in Q2.62, 14 terms, used at elaboration only.
    function automatic logic [14:0] sine_mag(input int unsigned j,
                                             input int unsigned table_bits);
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [127:0] scaled;
        logic [63:0]  hi;
        if (j == 0) begin
            return 15'd0;
        end
        x    = mul_q62(HALFPI_Q62, 64'(j) << (64 - table_bits));
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        term = mul_q62(term, x2) / 64'd6;   sum = sum - term;
        term = mul_q62(term, x2) / 64'd20;  sum = sum + term;
        term = mul_q62(term, x2) / 64'd42;  sum = sum - term;
        term = mul_q62(term, x2) / 64'd72;  sum = sum + term;
        term = mul_q62(term, x2) / 64'd110; sum = sum - term;
        term = mul_q62(term, x2) / 64'd156; sum = sum + term;
        term = mul_q62(term, x2) / 64'd210; sum = sum - term;
        term = mul_q62(term, x2) / 64'd272; sum = sum + term;
        term = mul_q62(term, x2) / 64'd342; sum = sum - term;
        term = mul_q62(term, x2) / 64'd420; sum = sum + term;
        term = mul_q62(term, x2) / 64'd506; sum = sum - term;
        term = mul_q62(term, x2) / 64'd600; sum = sum + term;
        term = mul_q62(term, x2) / 64'd702; sum = sum - term;
        // floor(32767 * sum / 2^62), clamped to the amplitude
        scaled = {64'b0, sum} * 128'(32'd131068);
        hi     = scaled[127:64];
        if (hi > 64'(AMPLITUDE)) begin
            hi = 64'(AMPLITUDE);
        end
        return hi[14:0];
    endfunction

endpackage

`default_nettype wire

[sv/sno_sine_rom.sv]
// Quarter-wave sine ROM with registered read data.
`default_nettype none

module sno_sine_rom #(
    parameter int unsigned TABLE_BITS = 10
) (
    input  wire logic                  aclk,
    input  wire logic                  rd_en,
    input  wire logic [TABLE_BITS-3:0] rd_addr,
    output logic      [14:0]           rd_data
);
    import sno_pkg::*;

    localparam int unsigned QN = 1 << (TABLE_BITS - 2);

    typedef logic [14:0] qtab_t [QN];

    // Table contents, computed at elaboration
    function automatic qtab_t build_table();
        qtab_t t;
        for (int unsigned i = 0; i < QN; i++) begin
            t[i] = sine_mag(i, TABLE_BITS);
        end
        return t;
    endfunction

    localparam qtab_t QTAB = build_table();

    logic [14:0] rd_data_reg;

    // Synchronous ROM read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= QTAB[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[sv/sno_phase_acc.sv]
// Tuning word, active flag and phase accumulator; forms the table lookup.
`default_nettype none

`include "sine_nco_oscillator_core_assert.svh"

module sno_phase_acc #(
    parameter int unsigned TABLE_BITS = 10
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   tick_acc,
    input  wire logic                   set_acc,
    input  wire logic [31:0]            frequency,
    input  wire logic [39:0]            step_per_hz,
    output logic      [TABLE_BITS-3:0]  lut_addr,
    output sno_pkg::sno_lut_flags_t     lut_flags
);
    import sno_pkg::*;

    localparam logic [TABLE_BITS-2:0] QUARTER = (TABLE_BITS-1)'(1) << (TABLE_BITS - 2);

    logic [31:0] phase_reg, phase_next;
    logic [31:0] tw_reg, tw_next;
    logic        active_reg, active_next;
    logic [71:0] tw_prod;

    logic [TABLE_BITS-1:0] idx;
    logic [TABLE_BITS-2:0] j_raw;
    logic [TABLE_BITS-2:0] j_fold;

    // Tuning word from a 16.16 frequency: (freq * step) >> 32, low 32 bits
    assign tw_prod = 72'(frequency) * 72'(step_per_hz);

    always_comb begin
        tw_next     = tw_reg;
        active_next = active_reg;
        phase_next  = phase_reg;
        if (set_acc) begin
            tw_next     = tw_prod[63:32];
            active_next = (frequency != 32'd0);
        end
        if (tick_acc) begin
            phase_next = active_reg ? phase_reg + tw_reg : 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= '0;
            tw_reg     <= '0;
            active_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            tw_reg     <= tw_next;
            active_reg <= active_next;
        end
    end

    // Quarter-wave fold of the top phase bits; past the quarter, half - j
    assign idx    = phase_reg[31 -: TABLE_BITS];
    assign j_raw  = idx[TABLE_BITS-2:0];
    assign j_fold = (j_raw > QUARTER) ? (TABLE_BITS-1)'(0) - j_raw : j_raw;

    assign lut_addr       = j_fold[TABLE_BITS-3:0];
    assign lut_flags.zero = !active_reg;
    assign lut_flags.neg  = idx[TABLE_BITS-1];
    assign lut_flags.peak = (j_fold == QUARTER);

    `SNO_ASSERT(idle_tick_clears_phase, aclk, aresetn, (tick_acc && !active_reg) |=> (phase_reg == 32'd0))
    `SNO_ASSERT(set_holds_phase, aclk, aresetn, (set_acc && !tick_acc) |=> $stable(phase_reg))
    `SNO_ASSERT(tick_advances_phase, aclk, aresetn, (tick_acc && active_reg) |=> (phase_reg == $past(phase_reg) + $past(tw_reg)))

endmodule

`default_nettype wire

[sv/sine_nco_oscillator_core.sv]
// Top level of the sine NCO: APB register, item handshake and output stage.
//
// Usage:
//   Input channel (s_valid/s_ready): s_kind = 1 loads a new frequency from
//   s_frequency (unsigned 16.16 Hz) and returns no item; s_kind = 0 is a tick
//   that returns one signed sample on the m_ channel.
//   The APB port holds step_per_hz (2^48 / sample rate) at byte address 0;
//   it only affects later frequency loads.
//   A tick's sample passes through the table read register, then the output
//   register, before it shows on m_valid.
//   Throughput: one item per cycle while the receiver keeps m_ready high,
//   set by the phase add and the one synchronous table read per sample.
//   Reset clears phase, tuning word and active flag, empties the pipeline
//   and restores step_per_hz. The oscillator starts idle (samples are zero).
//   When the receiver stalls, the output register holds its item, the table
//   stage holds one more, and s_ready drops only once both are full.
`default_nettype none

`include "sine_nco_oscillator_core_assert.svh"

module sine_nco_oscillator_core #(
    parameter int unsigned TABLE_BITS = 10
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // input items
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_kind,
    input  wire logic [31:0]        s_frequency,
    // result items
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_sample_value,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output logic      [63:0]        prdata,
    output logic                    pready
);
    import sno_pkg::*;

    logic [39:0] step_reg;
    logic        step_sel;

    logic        in_acc, tick_acc, set_acc;
    logic        s1_adv;
    logic        s1_valid_reg, s1_valid_next;
    sno_lut_flags_t s1_flags_reg;

    logic [TABLE_BITS-3:0] lut_addr;
    sno_lut_flags_t        lut_flags;
    logic [14:0]           rom_data;

    logic               m_valid_reg, m_valid_next;
    logic signed [15:0] m_sample_reg, m_sample_next;
    logic        [15:0] mag;

    // APB register file: one 40-bit register in a 64-bit slot
    assign pready   = 1'b1;
    assign step_sel = (paddr[3] == 1'(REG_STEP_PER_HZ));
    assign prdata   = step_sel ? {24'b0, step_reg} : 64'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_RESET;
        end else if (psel && penable && pwrite && pready && step_sel) begin
            step_reg <= pwdata[39:0];
        end
    end

    // Handshake: the table stage moves on when the output register is free
    assign s1_adv   = !m_valid_reg || m_ready;
    assign s_ready  = !s1_valid_reg || s1_adv;
    assign in_acc   = s_valid && s_ready;
    assign tick_acc = in_acc && !s_kind;
    assign set_acc  = in_acc && s_kind;

    sno_phase_acc #(
        .TABLE_BITS (TABLE_BITS)
    ) u_phase (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tick_acc    (tick_acc),
        .set_acc     (set_acc),
        .frequency   (s_frequency),
        .step_per_hz (step_reg),
        .lut_addr    (lut_addr),
        .lut_flags   (lut_flags)
    );

    sno_sine_rom #(
        .TABLE_BITS (TABLE_BITS)
    ) u_rom (
        .aclk    (aclk),
        .rd_en   (tick_acc),
        .rd_addr (lut_addr),
        .rd_data (rom_data)
    );

    // Table stage control, alongside the ROM read register
    assign s1_valid_next = s_ready ? tick_acc : s1_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_acc) begin
            s1_flags_reg <= lut_flags;
        end
    end

    // Sign and special cases applied to the table magnitude
    always_comb begin
        if (s1_flags_reg.zero) begin
            mag = 16'd0;
        end else if (s1_flags_reg.peak) begin
            mag = AMPLITUDE;
        end else begin
            mag = {1'b0, rom_data};
        end
        m_sample_next = s1_flags_reg.neg ? -$signed(mag) : $signed(mag);
        m_valid_next  = s1_adv ? s1_valid_reg : m_valid_reg;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_valid_reg) begin
            m_sample_reg <= m_sample_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_sample_value = m_sample_reg;

    `SNO_ASSERT_ALWAYS(reset_empties_pipe, aclk, !aresetn |=> (!m_valid_reg && !s1_valid_reg))
    `SNO_ASSERT(full_pipe_blocks_input, aclk, aresetn, (s1_valid_reg && m_valid_reg && !m_ready) |-> !s_ready)
    `SNO_ASSERT(sample_in_range, aclk, aresetn, m_valid_reg |-> (m_sample_reg != 16'sh8000))

endmodule

`default_nettype wire

[tb/sine_nco_oscillator_core_test.sv]
// Self-checking testbench for the sine NCO core: directed table, random items, APB setup.
module sine_nco_oscillator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sno_pkg::*;

    localparam int unsigned LUT_BITS   = 10;
    localparam int unsigned CYCLE_CAP  = 400000;
    localparam int unsigned ITEMS_EACH = 170;
    localparam int unsigned LONG_HOLD  = 300;
    localparam bit KIND_TICK = 1'b0;
    localparam bit KIND_SET  = 1'b1;

    // One directed item; want is used only where fixed is set
    typedef struct packed {
        bit                 kind;
        logic [31:0]        freq;
        bit                 fixed;
        logic signed [15:0] want;
    } stim_row_t;

    // Rows assume step_per_hz = 2^32, so the tuning word equals the frequency
    localparam stim_row_t DIRECTED [21] = '{
        '{KIND_TICK, 32'h0,        1'b1,  16'sd0},      // idle after reset
        '{KIND_SET,  32'h4000_0000, 1'b0, 16'sd0},      // quarter cycle per tick
        '{KIND_TICK, 32'h0,        1'b1,  16'sd0},
        '{KIND_TICK, 32'h0,        1'b1,  16'sd32767},
        '{KIND_TICK, 32'h0,        1'b1,  16'sd0},
        '{KIND_SET,  32'h0,        1'b0,  16'sd0},      // stop: phase gets cleared
        '{KIND_TICK, 32'h0,        1'b1,  16'sd0},
        '{KIND_SET,  32'h4000_0000, 1'b0, 16'sd0},
        '{KIND_TICK, 32'h0,        1'b1,  16'sd0},      // starts again from zero phase
        '{KIND_SET,  32'h8000_0000, 1'b0, 16'sd0},      // set keeps the phase
        '{KIND_TICK, 32'h0,        1'b1,  16'sd32767},
        '{KIND_TICK, 32'h0,        1'b1,  -16'sd32767},
        '{KIND_TICK, 32'h0,        1'b1,  16'sd32767},
        '{KIND_SET,  32'hFFFF_FFFF, 1'b0, 16'sd0},      // top frequency
        '{KIND_TICK, 32'h0,        1'b0,  16'sd0},
        '{KIND_TICK, 32'h0,        1'b0,  16'sd0},
        '{KIND_SET,  32'h0000_0001, 1'b0, 16'sd0},      // smallest nonzero step
        '{KIND_TICK, 32'h0,        1'b0,  16'sd0},
        '{KIND_TICK, 32'h0,        1'b0,  16'sd0},
        '{KIND_SET,  32'hC000_0000, 1'b0, 16'sd0},
        '{KIND_TICK, 32'hFFFF_FFFF, 1'b0, 16'sd0}
    };

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_kind;
    logic [31:0]        s_frequency;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_sample_value;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [63:0]        pwdata;
    logic [63:0]        prdata;
    logic               pready;

    // Oscillator model state
    logic [39:0]        step_reg;
    logic [31:0]        osc_phase;
    logic [31:0]        osc_tuning;
    bit                 osc_active;
    logic signed [15:0] sine_lut [1 << LUT_BITS];

    logic signed [15:0] sample_q [$];
    int unsigned        err_count;
    int unsigned        cycles;
    bit                 idle_on;
    bit                 long_hold_req;

    sine_nco_oscillator_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_frequency    (s_frequency),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_value (m_sample_value),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #1ns aclk = ~aclk;

    // Run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("sine_nco_oscillator_core_test: errors");
            $finish;
        end
    end

    // Truncated Q2.62 product
    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        return p[125:62];
    endfunction

    // Quarter-wave magnitude by Taylor series, strictly between 0 and the peak
    function automatic logic [15:0] series_mag(input int unsigned j);
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [127:0] scaled;
        x    = q62_mul(HALFPI_Q62, 64'(j) << (64 - LUT_BITS));
        x2   = q62_mul(x, x);
        term = x;
        sum  = x;
        for (int n = 1; n <= 13; n++) begin
            term = q62_mul(term, x2) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        scaled = {64'b0, sum} * 128'(32767 * 4);
        if (scaled[127:64] > 64'd32767) begin
            return 16'd32767;
        end
        return scaled[79:64];
    endfunction

    function automatic void build_sine_lut();
        int unsigned        half;
        int unsigned        quarter;
        int unsigned        j;
        logic [15:0]        mag;
        half    = 1 << (LUT_BITS - 1);
        quarter = 1 << (LUT_BITS - 2);
        for (int unsigned k = 0; k < (1 << LUT_BITS); k++) begin
            j = k & (half - 1);
            if (j > quarter) begin
                j = half - j;
            end
            if (j == 0) begin
                mag = 16'd0;
            end else if (j == quarter) begin
                mag = 16'd32767;
            end else begin
                mag = series_mag(j);
            end
            sine_lut[k] = ((k & half) != 0) ? -$signed(mag) : $signed(mag);
        end
    endfunction

    // Advance the oscillator by one item; returns 1 when a sample comes out
    function automatic bit osc_next(input bit kind, input logic [31:0] freq,
                                    output logic signed [15:0] smp);
        logic [71:0] prod;
        smp = '0;
        if (kind == KIND_SET) begin
            prod       = 72'(freq) * 72'(step_reg);
            osc_tuning = prod[63:32];
            osc_active = (freq != 32'd0);
            return 1'b0;
        end
        if (osc_active) begin
            smp       = sine_lut[osc_phase[31 -: LUT_BITS]];
            osc_phase = osc_phase + osc_tuning;
        end else begin
            osc_phase = '0;
        end
        return 1'b1;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Result side: random back-pressure plus one long hold-off on request
    initial begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= 1'b1;
                if (idle_on) begin
                    hold_left = pick_gap();
                end
            end
        end
    end

    // Compare each returned sample with the oldest expected one
    always @(posedge aclk) begin : sample_check
        logic signed [15:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (sample_q.size() == 0) begin
                $error("sample_value: unexpected item %0d", m_sample_value);
                err_count++;
            end else begin
                want = sample_q.pop_front();
                if (m_sample_value !== want) begin
                    $error("sample_value: expected %0d, got %0d", want, m_sample_value);
                    err_count++;
                end
            end
        end
    end

    // Offer one item and hold it until accepted; updates the model on acceptance
    task automatic offer_item(input bit kind, input logic [31:0] freq,
                              output bit has_smp, output logic signed [15:0] smp);
        s_valid     <= 1'b1;
        s_kind      <= kind;
        s_frequency <= freq;
        do @(posedge aclk); while (!s_ready);
        has_smp = osc_next(kind, freq, smp);
    endtask

    task automatic sender_pause();
        int unsigned g;
        g = idle_on ? pick_gap() : 0;
        if (g != 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    // Wait for all expected samples, then for anything still in the pipe
    task automatic settle();
        s_valid <= 1'b0;
        while (sample_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic read_step_check(input logic [39:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= 4'(8 * REG_STEP_PER_HZ);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== 64'(want)) begin
            $error("step_per_hz: expected %0d, got %0d", want, prdata);
            err_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_step(input logic [39:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(8 * REG_STEP_PER_HZ);
        pwdata  <= 64'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        step_reg = value;
        @(posedge aclk);
        read_step_check(value);
    endtask

    initial begin : main
        logic [39:0]        step_val;
        logic [31:0]        freq;
        bit                 kind;
        bit                 has_smp;
        logic signed [15:0] smp;

        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_kind      <= 1'b0;
        s_frequency <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        err_count   = 0;
        cycles      = 0;
        idle_on     = 1'b1;
        long_hold_req = 1'b0;
        step_reg    = STEP_RESET;
        osc_phase   = '0;
        osc_tuning  = '0;
        osc_active  = 1'b0;
        build_sine_lut();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Register comes up at its reset value
        read_step_check(STEP_RESET);

        // Directed items with tuning word equal to the frequency
        load_step(40'h01_0000_0000);
        foreach (DIRECTED[i]) begin
            offer_item(DIRECTED[i].kind, DIRECTED[i].freq, has_smp, smp);
            if (has_smp) begin
                sample_q.push_back(DIRECTED[i].fixed ? DIRECTED[i].want : smp);
            end
            sender_pause();
        end
        settle();

        // Random phases over several step settings, extremes included
        for (int p = 0; p < 5; p++) begin
            case (p)
                0:       step_val = STEP_RESET;
                1:       step_val = 40'd0;
                2:       step_val = 40'hFF_FFFF_FFFF;
                3:       step_val = {8'($urandom_range(0, 255)), 32'($urandom())};
                default: step_val = 40'd1;
            endcase
            load_step(step_val);
            // one phase runs without any idling, another gets the long hold-off
            idle_on = (p != 2);
            if (p == 3) begin
                long_hold_req = 1'b1;
            end
            repeat (ITEMS_EACH) begin
                kind = ($urandom_range(0, 3) == 0) ? KIND_SET : KIND_TICK;
                case ($urandom_range(0, 7))
                    0:       freq = 32'd0;
                    1:       freq = 32'($urandom_range(1, 15));
                    2:       freq = 32'd1 << $urandom_range(0, 31);
                    default: freq = $urandom();
                endcase
                offer_item(kind, freq, has_smp, smp);
                if (has_smp) begin
                    sample_q.push_back(smp);
                end
                sender_pause();
            end
            settle();
        end

        repeat (10) @(posedge aclk);
        if (err_count == 0) begin
            $display("sine_nco_oscillator_core_test: clean");
        end else begin
            $display("sine_nco_oscillator_core_test: errors");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/sno_pkg.sv
sv/sno_sine_rom.sv
sv/sno_phase_acc.sv
sv/sine_nco_oscillator_core.sv
tb/sine_nco_oscillator_core_test.sv
